/* sv/pra_pkg.sv */
// Package for the page reference-count allocator: constants, codes and control structs.
package pra_pkg;
  localparam int NUM_PAGES  = 131072;
  localparam int PAGE_BYTES = 4096;
  localparam int IDX_W      = $clog2(NUM_PAGES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int OFS_W      = $clog2(PAGE_BYTES);
  localparam int ADDR_W     = 36;
  localparam int PN_W       = ADDR_W - OFS_W;
  localparam int FREE_W     = 18;
  localparam int PCNT_W     = 18;

  localparam logic [2:0] OP_QUERY = 3'd0;
  localparam logic [2:0] OP_INC   = 3'd1;
  localparam logic [2:0] OP_DEC   = 3'd2;
  localparam logic [2:0] OP_SET   = 3'd3;
  localparam logic [2:0] OP_ALLOC = 3'd4;
  localparam logic [2:0] OP_ALLOCN = 3'd5;

  localparam logic [7:0] CODE_NOMEM = 8'd0;
  localparam logic [7:0] CODE_LEAK  = 8'd1;
  localparam logic [7:0] CODE_FREE  = 8'd2;
  localparam logic [7:0] CODE_USED1 = 8'd3;
  localparam logic [7:0] CODE_MAX   = 8'd255;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NOMEM = 3'd1;
  localparam logic [2:0] ST_DFREE = 3'd2;
  localparam logic [2:0] ST_OOM   = 3'd3;
  localparam logic [2:0] ST_OVF   = 3'd4;

  // commands from controller to datapath
  typedef struct packed {
    logic       clr_wr;     // write zero at idx, advance idx
    logic       load;       // capture input item
    logic       rd;         // read code at scan index
    logic       wr_item;    // write computed single-page result
    logic       wr_set;     // range-set write of current page
    logic       wr_alloc;   // write CODE_USED1 at scan index
    logic       idx_zero;   // scan index <- 0
    logic       idx_inc;    // scan index + 1
    logic       idx_start;  // scan index <- run start
    logic       run_upd;    // update run counter from read code
    logic       res_ok;     // latch result: single-page op
    logic       res_set;    // latch result: set range
    logic       res_alloc;  // latch result: alloc success
    logic       res_oom;    // latch result: out of memory
    logic       res_other;  // latch result: unused op
  } pra_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       addr_oob;   // page beyond table
    logic       set_empty;  // range set has no pages to visit
    logic       idx_last;   // scan index at final page
    logic       idx_at_end; // scan index reached range end
    logic       code_free;  // read code is free
    logic       run_hit;    // run reaches requested length
    logic       run_fill_done; // fill index reached run end
    logic       cnt_bad;    // page_count zero or too large
    logic       clr_done;
  } pra_sts_t;
endpackage

/* sv/pra_datapath.sv */
// Datapath of the page reference-count allocator: page code memory, scan index, free count.
module pra_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pra_pkg::pra_cmd_t             cmd,
  output pra_pkg::pra_sts_t             sts,
  input  logic [2:0]                    in_op,
  input  logic [pra_pkg::ADDR_W-1:0]    in_addr,
  input  logic [pra_pkg::ADDR_W-1:0]    in_top,
  input  logic [7:0]                    in_setv,
  input  logic [pra_pkg::PCNT_W-1:0]    in_cnt,
  output logic [2:0]                    res_status,
  output logic [8:0]                    res_ref,
  output logic [pra_pkg::ADDR_W-1:0]    res_addr,
  output logic [pra_pkg::FREE_W-1:0]    res_free
);
  logic [7:0] mem [pra_pkg::NUM_PAGES];
  logic [7:0] rdata_r;
  logic [2:0] op_r;
  logic [pra_pkg::PN_W-1:0] page_r, end_r;
  logic [7:0] setv_r;
  logic [pra_pkg::CNT_W-1:0] cnt_r, run_r;
  logic [pra_pkg::CNT_W-1:0] idx_r, idx_nxt, fill_end_r;
  logic [pra_pkg::CNT_W-1:0] free_r;
  logic [pra_pkg::IDX_W-1:0] ix;
  logic [pra_pkg::PN_W:0]   top_pg;
  logic [pra_pkg::PN_W-1:0] end_c;
  logic        we;
  logic [7:0]  wdata;
  logic [pra_pkg::CNT_W-1:0] run_nxt;
  logic [2:0]  st_c;
  logic [8:0]  rc_c;
  logic [7:0]  nv_c;
  logic        nw_c;

  assign ix = idx_r[pra_pkg::IDX_W-1:0];
  // one extra bit so rounding up the top page number cannot wrap
  assign top_pg = (pra_pkg::PN_W+1)'(in_top[pra_pkg::ADDR_W-1:pra_pkg::OFS_W])
                + (pra_pkg::PN_W+1)'(|in_top[pra_pkg::OFS_W-1:0]);
  assign end_c = (top_pg > (pra_pkg::PN_W+1)'(pra_pkg::NUM_PAGES)) ?
                 pra_pkg::PN_W'(pra_pkg::NUM_PAGES) : top_pg[pra_pkg::PN_W-1:0];

  // single-page op decode from read code
  always_comb begin
    st_c = pra_pkg::ST_OK; rc_c = 9'd0; nv_c = rdata_r; nw_c = 1'b0;
    case (op_r)
      pra_pkg::OP_QUERY: begin
        rc_c = (rdata_r == pra_pkg::CODE_NOMEM) ? 9'h1FF :
               (rdata_r == pra_pkg::CODE_LEAK) ? 9'd1 : {1'b0, rdata_r} - 9'd2;
      end
      pra_pkg::OP_INC: begin
        if (rdata_r < pra_pkg::CODE_FREE) rc_c = 9'd1;
        else if (rdata_r == pra_pkg::CODE_MAX) begin
          st_c = pra_pkg::ST_OVF; rc_c = 9'd253;
        end else begin
          nv_c = rdata_r + 8'd1; nw_c = 1'b1; rc_c = {1'b0, rdata_r} - 9'd1;
        end
      end
      pra_pkg::OP_DEC: begin
        if (rdata_r < pra_pkg::CODE_FREE) rc_c = 9'd1;
        else if (rdata_r == pra_pkg::CODE_FREE) st_c = pra_pkg::ST_DFREE;
        else begin
          nv_c = rdata_r - 8'd1; nw_c = 1'b1; rc_c = {1'b0, rdata_r} - 9'd3;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    we = 1'b0; wdata = 8'd0;
    if (cmd.clr_wr) begin we = 1'b1; wdata = pra_pkg::CODE_NOMEM; end
    else if (cmd.wr_item && nw_c) begin we = 1'b1; wdata = nv_c; end
    else if (cmd.wr_set && rdata_r != pra_pkg::CODE_LEAK) begin
      we = 1'b1; wdata = setv_r;
    end
    else if (cmd.wr_alloc) begin we = 1'b1; wdata = pra_pkg::CODE_USED1; end
  end

  // single-port code memory, read data registered
  always_ff @(posedge clk) begin
    if (we) mem[ix] <= wdata;
    if (cmd.rd) rdata_r <= mem[ix];
  end

  assign run_nxt = (rdata_r == pra_pkg::CODE_FREE) ? run_r + 1'b1 : '0;

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load)
      idx_nxt = (in_op == pra_pkg::OP_ALLOC || in_op == pra_pkg::OP_ALLOCN) ? '0 :
                pra_pkg::CNT_W'(in_addr[pra_pkg::ADDR_W-1:pra_pkg::OFS_W]);
    else if (cmd.idx_zero) idx_nxt = '0;
    else if (cmd.idx_start) idx_nxt = idx_r + 1'b1 - run_nxt;
    else if (cmd.idx_inc || cmd.clr_wr) idx_nxt = idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      free_r <= '0;
      run_r  <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (cmd.load) run_r <= '0;
      else if (cmd.run_upd) run_r <= run_nxt;
      if (we && !cmd.clr_wr)
        free_r <= free_r - pra_pkg::CNT_W'(rdata_r == pra_pkg::CODE_FREE || cmd.wr_alloc)
                         + pra_pkg::CNT_W'(wdata == pra_pkg::CODE_FREE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      page_r <= in_addr[pra_pkg::ADDR_W-1:pra_pkg::OFS_W];
      end_r  <= end_c;
      setv_r <= in_setv;
      cnt_r  <= pra_pkg::CNT_W'(in_cnt);
    end
    if (cmd.idx_start) fill_end_r <= idx_r;
    if (cmd.res_ok) begin
      res_status <= page_r >= pra_pkg::PN_W'(pra_pkg::NUM_PAGES) ? pra_pkg::ST_NOMEM : st_c;
      res_ref    <= page_r >= pra_pkg::PN_W'(pra_pkg::NUM_PAGES) ? 9'h1FF : rc_c;
      res_addr   <= '0;
    end else if (cmd.res_set || cmd.res_other || cmd.res_oom) begin
      res_status <= cmd.res_oom ? pra_pkg::ST_OOM : pra_pkg::ST_OK;
      res_ref    <= '0;
      res_addr   <= '0;
    end else if (cmd.res_alloc) begin
      res_status <= pra_pkg::ST_OK;
      res_ref    <= 9'd1;
      res_addr   <= pra_pkg::ADDR_W'({ix, {pra_pkg::OFS_W{1'b0}}});
    end
  end

  assign res_free = free_r[pra_pkg::FREE_W-1:0];

  assign sts.op = op_r;
  assign sts.addr_oob = page_r >= pra_pkg::PN_W'(pra_pkg::NUM_PAGES);
  assign sts.set_empty = page_r >= end_r;
  assign sts.idx_last = idx_r == pra_pkg::CNT_W'(pra_pkg::NUM_PAGES - 1);
  assign sts.idx_at_end = pra_pkg::PN_W'(idx_r) + 1'b1 >= end_r;
  assign sts.code_free = rdata_r == pra_pkg::CODE_FREE;
  assign sts.run_hit = run_nxt == cnt_r;
  assign sts.run_fill_done = idx_r == fill_end_r;
  assign sts.cnt_bad = cnt_r == '0 || cnt_r > pra_pkg::CNT_W'(pra_pkg::NUM_PAGES);
  assign sts.clr_done = idx_r == pra_pkg::CNT_W'(pra_pkg::NUM_PAGES - 1);
endmodule

/* sv/pra_ctrl.sv */
// Controller state machine of the page reference-count allocator.
module pra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  output logic              in_ready,
  output logic              res_valid,
  input  logic              res_taken,
  input  pra_pkg::pra_sts_t sts,
  output pra_pkg::pra_cmd_t cmd
);
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_ITEM  = 4'd3;
  localparam logic [3:0] S_SET   = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_FILLR = 4'd6;
  localparam logic [3:0] S_FILL  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_SETR  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       vld_r, vld_nxt, done;

  assign in_ready  = state_r == S_IDLE && (!vld_r || res_taken);
  assign res_valid = vld_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    done = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin cmd.load = 1'b1; state_nxt = S_RD; end
      end
      S_RD: begin
        case (sts.op)
          pra_pkg::OP_QUERY, pra_pkg::OP_INC, pra_pkg::OP_DEC: begin
            if (sts.addr_oob) begin cmd.res_ok = 1'b1; done = 1'b1; end
            else begin cmd.rd = 1'b1; state_nxt = S_ITEM; end
          end
          pra_pkg::OP_SET: begin
            if (sts.set_empty) begin cmd.res_set = 1'b1; done = 1'b1; end
            else begin cmd.rd = 1'b1; state_nxt = S_SET; end
          end
          pra_pkg::OP_ALLOC: begin cmd.rd = 1'b1; state_nxt = S_SCAN; end
          pra_pkg::OP_ALLOCN: begin
            if (sts.cnt_bad) begin cmd.res_oom = 1'b1; done = 1'b1; end
            else begin cmd.rd = 1'b1; state_nxt = S_SCAN; end
          end
          default: begin cmd.res_other = 1'b1; done = 1'b1; end
        endcase
      end
      S_ITEM: begin
        cmd.wr_item = 1'b1; cmd.res_ok = 1'b1; done = 1'b1;
      end
      S_SET: begin
        cmd.wr_set = 1'b1;
        if (sts.idx_at_end) begin cmd.res_set = 1'b1; done = 1'b1; end
        else begin cmd.idx_inc = 1'b1; state_nxt = S_SETR; end
      end
      S_SETR: begin cmd.rd = 1'b1; state_nxt = S_SET; end
      S_SCAN: begin
        // code for idx is in the read register
        if (sts.op == pra_pkg::OP_ALLOC) begin
          if (sts.code_free) begin
            cmd.wr_alloc = 1'b1; cmd.res_alloc = 1'b1; done = 1'b1;
          end else if (sts.idx_last) begin cmd.res_oom = 1'b1; done = 1'b1; end
          else begin cmd.idx_inc = 1'b1; state_nxt = S_OUT; end
        end else begin
          cmd.run_upd = 1'b1;
          if (sts.code_free && sts.run_hit) begin
            cmd.idx_start = 1'b1; state_nxt = S_FILLR;
          end else if (sts.idx_last) begin cmd.res_oom = 1'b1; done = 1'b1; end
          else begin cmd.idx_inc = 1'b1; state_nxt = S_OUT; end
        end
      end
      S_FILLR: begin
        cmd.res_alloc = 1'b1; state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.wr_alloc = 1'b1;
        if (sts.run_fill_done) done = 1'b1;
        else cmd.idx_inc = 1'b1;
      end
      S_OUT: begin cmd.rd = 1'b1; state_nxt = S_SCAN; end
      default: state_nxt = S_IDLE;
    endcase
    if (done) state_nxt = S_IDLE;
  end

  always_comb begin
    vld_nxt = vld_r;
    if (res_taken) vld_nxt = 1'b0;
    if (done) vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
  end
endmodule

/* sv/page_refcount_allocator.sv */
// Top level of the page reference-count allocator.
// Keeps one 8-bit code per physical page in an on-chip memory with one port. After reset a
// clearing pass writes every page to "no memory", during which no item is taken. Query,
// increment and decrement load, read and write; with an address beyond the table they skip
// the read and the write. Set range reads each page in range and writes it unless it holds
// the leak code; allocate page and allocate contiguous read each page scanned from page 0
// and write the pages found on success. The memory port serves a read or a write at a time.
// A new item is taken only once the previous result is transferred or is being transferred
// in the same cycle, so the free count in a result never runs ahead.
module page_refcount_allocator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[2:0], address[38:3], top_address[74:39], set_value[82:75], page_count[100:83]
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], ref_count[11:3], alloc_address[47:12], free_pages[65:48]
  output logic [71:0]  out_tdata
);
  pra_pkg::pra_cmd_t cmd;
  pra_pkg::pra_sts_t sts;
  logic [2:0]  res_status;
  logic [8:0]  res_ref;
  logic [35:0] res_addr;
  logic [17:0] res_free;

  pra_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_tvalid && in_tready), .in_ready(in_tready),
    .res_valid(out_tvalid), .res_taken(out_tvalid && out_tready),
    .sts(sts), .cmd(cmd)
  );

  pra_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_tdata[2:0]), .in_addr(in_tdata[38:3]),
    .in_top(in_tdata[74:39]), .in_setv(in_tdata[82:75]),
    .in_cnt(in_tdata[100:83]),
    .res_status(res_status), .res_ref(res_ref), .res_addr(res_addr), .res_free(res_free)
  );

  assign out_tdata = {6'd0, res_free, res_addr, res_ref, res_status};
endmodule
